// ===== hw/rtl/h2r_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared types and helpers for the HSL to RGB color converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

	// Sextant codes
	localparam logic [2:0] SEXT_RED_UP   = 3'd0;
	localparam logic [2:0] SEXT_GRN_DOWN = 3'd1;
	localparam logic [2:0] SEXT_GRN_UP   = 3'd2;
	localparam logic [2:0] SEXT_BLU_DOWN = 3'd3;
	localparam logic [2:0] SEXT_BLU_UP   = 3'd4;
	localparam logic [2:0] SEXT_RED_DOWN = 3'd5;

	typedef struct packed {
		logic [15:0] hue;
		logic [7:0]  saturation;
		logic [7:0]  lightness;
	} h2r_in_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [23:0] packed_color;
	} h2r_out_t;

	// Channel selection controls
	typedef struct packed {
		logic [2:0] sextant;
		logic       gray;
		logic [7:0] lightness;
	} h2r_sel_t;

	// floor(x / 255), exact for x up to 65279 (covers every V, M and ramp value)
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/h2r_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2r stream interfaces
// Valid/ready channels for HSL input triples and RGB results.
// ----------------------------------------------------------------------------
interface h2r_in_if;
	logic               valid;
	logic               ready;
	h2r_pkg::h2r_in_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface h2r_out_if;
	logic               valid;
	logic               ready;
	h2r_pkg::h2r_out_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/h2r_chan_sel.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2r_chan_sel
// Scales v, m and the two ramp values to 8 bits and routes them by sextant; gray forces lightness.
// ----------------------------------------------------------------------------
module h2r_chan_sel (
	input  wire logic [15:0]       big_v,
	input  wire logic [15:0]       big_m,
	input  wire logic [15:0]       ramp_up,
	input  wire logic [15:0]       ramp_dn,
	input  wire h2r_pkg::h2r_sel_t sel,
	output h2r_pkg::h2r_out_t      rgb
);
	import h2r_pkg::*;

	logic [7:0] cv, cm, mid1, mid2;
	logic [7:0] r, g, b;

	always_comb begin
		cv   = div255(big_v);
		cm   = div255(big_m);
		mid1 = div255(ramp_up);
		mid2 = div255(ramp_dn);
		case (sel.sextant)
			SEXT_RED_UP:   begin r = cv;   g = mid1; b = cm;   end
			SEXT_GRN_DOWN: begin r = mid2; g = cv;   b = cm;   end
			SEXT_GRN_UP:   begin r = cm;   g = cv;   b = mid1; end
			SEXT_BLU_DOWN: begin r = cm;   g = mid2; b = cv;   end
			SEXT_BLU_UP:   begin r = mid1; g = cm;   b = cv;   end
			default:       begin r = cv;   g = cm;   b = mid2; end
		endcase
		if (sel.gray) begin
			r = sel.lightness;
			g = sel.lightness;
			b = sel.lightness;
		end
		rgb.red          = r;
		rgb.green        = g;
		rgb.blue         = b;
		rgb.packed_color = {r, g, b};
	end

endmodule
`default_nettype wire

// ===== hw/rtl/hsl_to_rgb_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Five-stage pipelined HSL to 8-bit RGB converter with packed 24-bit output.
// ----------------------------------------------------------------------------
//  channel   dir  payload                              transaction
//  pix_in    in   hue[16] saturation[8] lightness[8]   one HSL triple
//  pix_out   out  red green blue[8] packed_color[24]   one RGB result
//
//  Five register stages: an accepted transaction enters s1, moves through
//  s2, s3 and s4 and is offered on pix_out from s5; throughput is one
//  transaction per clock while pix_out is ready. The stage count is set
//  by the 8x8 product L*S, the chroma add chain, the C*fraction multiplier,
//  the ramp adds and the divide-by-255 and sextant mux, one per stage.
//  Each stage loads when it is empty or its successor moves, so bubbles
//  collapse and input keeps flowing while a result waits on pix_out, until
//  the four stages behind it are full.
//  arst_n clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter #(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	h2r_in_if.sink     pix_in,
	h2r_out_if.source  pix_out
);
	import h2r_pkg::*;

	localparam int FB = FRACTION_BITS;
	localparam int PW = 16 + FB;

	// Stage valid bits and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5 = !v_s5 || pix_out.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign pix_in.ready = en_s1;

	// Stage 1: L*S product and hue*6
	logic [7:0]  lit_s1, sat_s1;
	logic [15:0] ls_s1;
	logic [18:0] h6_s1;

	// Stage 2: V, M, C, sextant and fraction
	logic [7:0]    lit_s2;
	logic [15:0]   bv_s2, bm_s2, bc_s2;
	logic [2:0]    sext_s2;
	logic [FB-1:0] fq_s2;

	// Stage 3: C * fraction
	logic [7:0]  lit_s3;
	logic [15:0] bv_s3, bm_s3;
	logic [2:0]  sext_s3;
	logic [PW-1:0] prod_s3;

	// Stage 4: ramp numerators already shifted by FB
	h2r_sel_t    sel_s4;
	logic [15:0] bv_s4, bm_s4, up_s4, dn_s4;

	// Stage 5: output register
	h2r_out_t    rgb_s5;

	// Stage 2 combinational: chroma top and floor in units of 1/65025
	logic [17:0] bv_lo, bv_hi, bm_full;
	logic [15:0] bv_c, bm_c;
	logic [23:0] fr_wide;

	always_comb begin
		bv_lo   = ({2'd0, lit_s1, 8'd0} - {10'd0, lit_s1}) + {2'd0, ls_s1};
		bv_hi   = ({1'b0, ({1'b0, lit_s1} + {1'b0, sat_s1}), 8'd0}
		           - {9'd0, ({1'b0, lit_s1} + {1'b0, sat_s1})}) - {2'd0, ls_s1};
		bv_c    = lit_s1[7] ? bv_hi[15:0] : bv_lo[15:0];
		bm_full = {1'b0, lit_s1, 9'd0} - {9'd0, lit_s1, 1'b0} - {2'd0, bv_c};
		bm_c    = bm_full[15:0];
		fr_wide = {h6_s1[15:0], 8'd0};
	end

	// Stage 4 combinational: integer part and sticky of the ramp product
	logic [15:0] prod_int;
	logic        prod_sticky;
	logic [16:0] up_c, dn_c;

	always_comb begin
		prod_int    = prod_s3[PW-1:FB];
		prod_sticky = |prod_s3[FB-1:0];
		up_c        = {1'b0, bm_s3} + {1'b0, prod_int};
		dn_c        = {1'b0, bv_s3} - {1'b0, prod_int} - {16'd0, prod_sticky};
	end

	// Stage 5 combinational: scale and route
	h2r_out_t rgb_c;

	h2r_chan_sel u_chan_sel (
		.big_v   (bv_s4),
		.big_m   (bm_s4),
		.ramp_up (up_s4),
		.ramp_dn (dn_s4),
		.sel     (sel_s4),
		.rgb     (rgb_c)
	);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix_in.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Data registers
	always_ff @(posedge clk) begin
		if (en_s1 && pix_in.valid) begin
			lit_s1 <= pix_in.payload.lightness;
			sat_s1 <= pix_in.payload.saturation;
			ls_s1  <= pix_in.payload.lightness * pix_in.payload.saturation;
			h6_s1  <= {1'b0, pix_in.payload.hue, 2'd0} + {2'd0, pix_in.payload.hue, 1'b0};
		end
		if (en_s2 && v_s1) begin
			lit_s2  <= lit_s1;
			bv_s2   <= bv_c;
			bm_s2   <= bm_c;
			bc_s2   <= bv_c - bm_c;
			sext_s2 <= h6_s1[18:16];
			fq_s2   <= fr_wide[23 -: FB];
		end
		if (en_s3 && v_s2) begin
			lit_s3  <= lit_s2;
			bv_s3   <= bv_s2;
			bm_s3   <= bm_s2;
			sext_s3 <= sext_s2;
			prod_s3 <= PW'(bc_s2) * PW'(fq_s2);
		end
		if (en_s4 && v_s3) begin
			sel_s4.sextant   <= sext_s3;
			sel_s4.gray      <= (bv_s3 == 16'd0);
			sel_s4.lightness <= lit_s3;
			bv_s4 <= bv_s3;
			bm_s4 <= bm_s3;
			up_s4 <= up_c[15:0];
			dn_s4 <= dn_c[15:0];
		end
		if (en_s5 && v_s4) begin
			rgb_s5 <= rgb_c;
		end
	end

	assign pix_out.valid   = v_s5;
	assign pix_out.payload = rgb_s5;

	// Checks
	a_accept_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_in.valid && pix_in.ready) |=> v_s1)
		else $error("accepted transaction did not enter stage 1");

	a_stalled_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !pix_out.ready) |=> (v_s5 && $stable(rgb_s5)))
		else $error("stalled result was dropped or changed");

	a_floor_below_top: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (bm_s2 <= bv_s2))
		else $error("chroma floor above chroma top");

	a_packed_matches: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (rgb_s5.packed_color == {rgb_s5.red, rgb_s5.green, rgb_s5.blue}))
		else $error("packed color disagrees with channels");

endmodule
`default_nettype wire

// ===== verif/hsl_rgb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_rgb_checker
// Watches both converter channels, computes the RGB color that each accepted
// HSL transaction must produce, and compares results in arrival order.
// ----------------------------------------------------------------------------
module hsl_rgb_checker #(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	h2r_in_if         pix_in,
	h2r_out_if        pix_out,
	output int        mismatches,
	output int        outstanding,
	output int        colors_in,
	output int        colors_out
);
	import h2r_pkg::*;

	h2r_out_t rgb_pending[$];

	// Exact integer HSL to RGB: V, M, C in units of 1/65025, floor per channel
	function automatic h2r_out_t convert_hsl(input h2r_in_t px);
		logic [63:0] lit;
		logic [63:0] sat;
		logic [63:0] big_v;
		logic [63:0] big_m;
		logic [63:0] chroma;
		logic [63:0] unit_one;
		logic [18:0] h6;
		logic [2:0]  sextant;
		logic [15:0] fr;
		logic [23:0] fq;
		logic [7:0]  cv;
		logic [7:0]  cm;
		logic [7:0]  ramp_up;
		logic [7:0]  ramp_dn;
		h2r_out_t    rgb;
		lit = 64'(px.lightness);
		sat = 64'(px.saturation);
		rgb.red   = px.lightness;
		rgb.green = px.lightness;
		rgb.blue  = px.lightness;
		if (px.lightness <= 8'd127) begin
			big_v = lit * (64'd255 + sat);
		end else begin
			big_v = 64'd255 * lit + 64'd255 * sat - lit * sat;
		end
		if (big_v != 64'd0) begin
			big_m    = 64'd510 * lit - big_v;
			chroma   = big_v - big_m;
			h6       = 19'(px.hue) * 19'd6;
			sextant  = h6[18:16];
			fr       = h6[15:0];
			fq       = {fr, 8'd0} >> (24 - FRACTION_BITS);
			unit_one = 64'd1 << FRACTION_BITS;
			cv       = 8'(big_v / 64'd255);
			cm       = 8'(big_m / 64'd255);
			ramp_up  = 8'((big_m * unit_one + chroma * 64'(fq)) / (64'd255 * unit_one));
			ramp_dn  = 8'((big_v * unit_one - chroma * 64'(fq)) / (64'd255 * unit_one));
			case (sextant)
				SEXT_RED_UP: begin
					rgb.red = cv;      rgb.green = ramp_up; rgb.blue = cm;
				end
				SEXT_GRN_DOWN: begin
					rgb.red = ramp_dn; rgb.green = cv;      rgb.blue = cm;
				end
				SEXT_GRN_UP: begin
					rgb.red = cm;      rgb.green = cv;      rgb.blue = ramp_up;
				end
				SEXT_BLU_DOWN: begin
					rgb.red = cm;      rgb.green = ramp_dn; rgb.blue = cv;
				end
				SEXT_BLU_UP: begin
					rgb.red = ramp_up; rgb.green = cm;      rgb.blue = cv;
				end
				default: begin
					rgb.red = cv;      rgb.green = cm;      rgb.blue = ramp_dn;
				end
			endcase
		end
		rgb.packed_color = {rgb.red, rgb.green, rgb.blue};
		return rgb;
	endfunction

	initial begin
		mismatches  = 0;
		outstanding = 0;
		colors_in   = 0;
		colors_out  = 0;
	end

	always @(posedge clk) begin
		h2r_out_t want;
		h2r_out_t got;
		int       errs;
		errs = 0;
		if (arst_n) begin
			if (pix_out.valid && pix_out.ready) begin
				got = pix_out.payload;
				colors_out <= colors_out + 1;
				if (rgb_pending.size() == 0) begin
					$error("unexpected result: packed_color %06h", got.packed_color);
					errs = errs + 1;
				end else begin
					want = rgb_pending.pop_front();
					if (got.red !== want.red) begin
						$error("red: expected %0d, actual %0d", want.red, got.red);
						errs = errs + 1;
					end
					if (got.green !== want.green) begin
						$error("green: expected %0d, actual %0d", want.green, got.green);
						errs = errs + 1;
					end
					if (got.blue !== want.blue) begin
						$error("blue: expected %0d, actual %0d", want.blue, got.blue);
						errs = errs + 1;
					end
					if (got.packed_color !== want.packed_color) begin
						$error("packed_color: expected %06h, actual %06h",
							want.packed_color, got.packed_color);
						errs = errs + 1;
					end
				end
			end
			if (pix_in.valid && pix_in.ready) begin
				rgb_pending.push_back(convert_hsl(pix_in.payload));
				colors_in <= colors_in + 1;
			end
			if (errs != 0) begin
				mismatches <= mismatches + errs;
			end
			outstanding <= rgb_pending.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives HSL triples into the converter in random bursts while the result
// side stalls on its own varying pattern; the checker judges every color.
// ----------------------------------------------------------------------------
module testbench;
	import h2r_pkg::*;

	localparam int FRACTION_BITS = 16;
	localparam int RANDOM_COLORS = 650;
	localparam int DRAIN_LIMIT   = 5000;

	// Output-side stall styles, rotated at random
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_COIN,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic clk;
	logic arst_n;

	h2r_in_if  pix_in_ch();
	h2r_out_if pix_out_ch();

	int mismatches;
	int outstanding;
	int colors_in;
	int colors_out;

	// Sender burst bookkeeping
	int burst_left;
	int drain_cycles;
	int pick;

	// Sextant boundary hues: last hue of each sextant, first of the next is +1
	logic [15:0] boundary_hue[5] = '{16'd10922, 16'd21845, 16'd32767, 16'd43690, 16'd54613};
	// Saturation and lightness corner values, including the 127/128 split
	logic [7:0]  corner_val[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};

	hsl_to_rgb_converter #(
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_ch.sink),
		.pix_out (pix_out_ch.source)
	);

	hsl_rgb_checker #(
		.FRACTION_BITS(FRACTION_BITS)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_in      (pix_in_ch),
		.pix_out     (pix_out_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.colors_in   (colors_in),
		.colors_out  (colors_out)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Timeout: converter stopped making progress");
		$display("Mismatches found");
		$finish;
	end

	// Result-side ready: each stretch picks a stall style and a length.
	// Heavy mode averages one ready in eight, so results back up into the
	// pipeline and the input side sees backpressure.
	initial begin
		stall_mode_t mode;
		int          span;
		int          phase;
		pix_out_ch.ready = 1'b0;
		phase = 0;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				phase = phase + 1;
				case (mode)
					STALL_NONE:     pix_out_ch.ready <= 1'b1;
					STALL_COIN:     pix_out_ch.ready <= 1'($urandom);
					STALL_HEAVY:    pix_out_ch.ready <= ($urandom_range(0, 7) == 0);
					default:        pix_out_ch.ready <= (phase % 5 != 0);
				endcase
			end
		end
	end

	// One HSL transaction. Between bursts valid drops before it rises
	// again, so it is never lowered and raised in the same step. Returns
	// at the falling edge after the transaction was accepted.
	task automatic send_color(input logic [15:0] hue, input logic [7:0] sat,
			input logic [7:0] lit);
		h2r_in_t px;
		if (burst_left == 0) begin
			pix_in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			// Long bursts give stretches with no input idling at all
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		px.hue        = hue;
		px.saturation = sat;
		px.lightness  = lit;
		pix_in_ch.payload <= px;
		pix_in_ch.valid   <= 1'b1;
		do @(posedge clk); while (!pix_in_ch.ready);
		@(negedge clk);
		burst_left = burst_left - 1;
	endtask

	initial begin
		pix_in_ch.valid   = 1'b0;
		pix_in_ch.payload = '0;
		burst_left        = 0;
		arst_n            = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: gray (lightness zero), hue extremes
		send_color(16'd0,     8'd255, 8'd0);
		send_color(16'd65535, 8'd0,   8'd0);
		send_color(16'd0,     8'd255, 8'd127);
		send_color(16'd65535, 8'd255, 8'd128);
		// Zero saturation: v equals m, every channel equals floor(l)
		send_color(16'd30000, 8'd0,   8'd100);
		send_color(16'd0,     8'd0,   8'd255);
		// Saturation and lightness extremes
		send_color(16'd12345, 8'd255, 8'd255);
		send_color(16'd50000, 8'd255, 8'd1);
		send_color(16'd40000, 8'd1,   8'd254);
		// Both sides of every sextant boundary: exercises all six sextants
		// and the ramp at fraction near one and near zero
		foreach (boundary_hue[i]) begin
			send_color(boundary_hue[i],         8'd255, 8'd127);
			send_color(boundary_hue[i] + 16'd1, 8'd200, 8'd128);
		end
		// Top of the hue range stays in the last sextant
		send_color(16'd65535, 8'd255, 8'd127);
		send_color(16'd65534, 8'd128, 8'd64);

		// Random mix: mostly uniform, some corner levels, some boundary hues
		repeat (RANDOM_COLORS) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				send_color(16'($urandom),
					corner_val[$urandom_range(0, 5)],
					corner_val[$urandom_range(0, 5)]);
			end else if (pick == 1) begin
				send_color(boundary_hue[$urandom_range(0, 4)]
					+ 16'($urandom_range(0, 6)) - 16'd3,
					8'($urandom), 8'($urandom));
			end else begin
				send_color(16'($urandom), 8'($urandom), 8'($urandom));
			end
		end
		pix_in_ch.valid <= 1'b0;

		// Drain: wait for every expected color, then wait once more before checking
		drain_cycles = 0;
		while (outstanding != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(negedge clk);
			drain_cycles = drain_cycles + 1;
		end
		repeat (10) @(negedge clk);
		if (outstanding != 0) begin
			$error("%0d expected colors never came out", outstanding);
		end

		$display("Converted %0d HSL triples, checked %0d RGB results", colors_in, colors_out);
		$display("Covered all sextants, gray, corner levels, bursty input, varied stalls");
		if (mismatches == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
